// ===== design/telecontrol_apdu_slave_engine_defines.svh =====
// assertion macros used by the checker file
`ifndef TELECONTROL_APDU_SLAVE_ENGINE_DEFINES_SVH
`define TELECONTROL_APDU_SLAVE_ENGINE_DEFINES_SVH

// condition implies consequence in the same cycle
`define TCAS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition implies consequence in the next cycle
`define TCAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/tcas_pkg.sv =====
// types and constants of the telecontrol apdu slave engine
package tcas_pkg;

  localparam int STORE_BYTES = 14;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CONN  = 2'd1;
  localparam logic [1:0] KIND_POINT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COMMON_ADDR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_IOA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_IOA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_IOA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_WORD = 3'd5;

  localparam logic [7:0] START_BYTE    = 8'h68;
  localparam logic [7:0] FN_START_ACT  = 8'h07;
  localparam logic [7:0] FN_START_CON  = 8'h0B;
  localparam logic [7:0] FN_STOP_ACT   = 8'h13;
  localparam logic [7:0] FN_STOP_CON   = 8'h23;
  localparam logic [7:0] FN_TEST_ACT   = 8'h43;
  localparam logic [7:0] FN_TEST_CON   = 8'h83;
  localparam logic [7:0] TYPE_SC       = 8'd45;
  localparam logic [7:0] TYPE_GI       = 8'd100;
  localparam logic [7:0] TYPE_SP       = 8'd1;
  localparam logic [7:0] TYPE_FLOAT    = 8'd13;
  localparam logic [7:0] COT_SPONT     = 8'd3;
  localparam logic [7:0] COT_ACTCON    = 8'h07;
  localparam logic [7:0] COT_ACTTERM   = 8'd10;
  localparam logic [7:0] COT_INROGEN   = 8'd20;

  typedef enum logic [5:0] {
    FR_U       = 6'b000001,
    FR_ECHO7   = 6'b000010,
    FR_POINT20 = 6'b000100,
    FR_VOLT    = 6'b001000,
    FR_ECHO10  = 6'b010000,
    FR_POINT3  = 6'b100000
  } frame_kind_t;

  typedef struct packed {
    logic [15:0] common_address;
    logic [23:0] control_ioa;
    logic [23:0] point_ioa;
    logic [23:0] voltage_ioa;
    logic        voltage_en;
    logic [31:0] voltage_word;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    frame_kind_t first;
    logic        gi;
    logic [7:0]  ufn;
    logic [14:0] ssn;
    logic [14:0] rsn;
    logic [79:0] asdu;
  } job_t;

endpackage

// ===== design/tcas_rx.sv =====
// receive deframer, session state and frame decode into a response job
module tcas_rx (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         kind,
  input  logic [7:0]         rx_byte,
  input  logic               point_value,
  input  tcas_pkg::cfg_t     cfg,
  output tcas_pkg::job_t     job,
  output logic               point_bit
);
  import tcas_pkg::*;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_LEN   = 3'b010,
    PH_BODY  = 3'b100
  } rx_phase_t;

  rx_phase_t   rx_phase, rx_phase_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  body_count, body_count_next;
  logic [7:0]  body_store [STORE_BYTES];
  logic        session_started, session_started_next;
  logic [14:0] send_sequence, send_sequence_next;
  logic [14:0] receive_sequence, receive_sequence_next;
  logic        point_bit_next;

  logic [7:0]  body [STORE_BYTES];
  logic [7:0]  body_inc;
  logic [7:0]  c0;
  logic [23:0] ioa;

  always_comb begin
    for (int i = 0; i < STORE_BYTES; i++) begin
      body[i] = (body_count == 8'(i)) ? rx_byte : body_store[i];
    end
    body_inc = body_count + 8'd1;
    c0 = body[0];
    ioa = {body[12], body[11], body[10]};
  end

  always_comb begin
    rx_phase_next = rx_phase;
    frame_length_next = frame_length;
    body_count_next = body_count;
    session_started_next = session_started;
    send_sequence_next = send_sequence;
    receive_sequence_next = receive_sequence;
    point_bit_next = point_bit;
    job = '0;
    job.first = FR_U;
    job.ssn = send_sequence;
    for (int k = 0; k < 10; k++) begin
      job.asdu[8*k +: 8] = body[4+k];
    end
    if (accept) begin
      case (kind)
        KIND_BYTE: begin
          case (rx_phase)
            PH_LEN: begin
              frame_length_next = rx_byte;
              if (rx_byte < 8'd4) begin
                rx_phase_next = PH_START;
              end else begin
                body_count_next = '0;
                rx_phase_next = PH_BODY;
              end
            end
            PH_BODY: begin
              body_count_next = body_inc;
              if (body_inc >= frame_length) begin
                rx_phase_next = PH_START;
                if (!c0[0]) begin
                  receive_sequence_next = {body[1], c0[7:1]} + 15'd1;
                  if (frame_length >= 8'd14) begin
                    if (body[4] == TYPE_SC && ioa == cfg.control_ioa) begin
                      point_bit_next = body[13][0];
                      job.valid = 1'b1;
                      job.first = FR_ECHO7;
                      send_sequence_next = send_sequence + 15'd1;
                    end else if (body[4] == TYPE_GI) begin
                      job.valid = 1'b1;
                      job.first = FR_ECHO7;
                      job.gi = 1'b1;
                      send_sequence_next = send_sequence + (cfg.voltage_en ? 15'd4 : 15'd3);
                    end
                  end
                end else if (c0[1:0] == 2'b01) begin
                  job.valid = 1'b0;
                end else if (c0 == FN_START_ACT) begin
                  session_started_next = 1'b1;
                  send_sequence_next = '0;
                  receive_sequence_next = '0;
                  job.valid = 1'b1;
                  job.ufn = FN_START_CON;
                end else if (c0 == FN_STOP_ACT) begin
                  session_started_next = 1'b0;
                  job.valid = 1'b1;
                  job.ufn = FN_STOP_CON;
                end else if (c0 == FN_TEST_ACT) begin
                  job.valid = 1'b1;
                  job.ufn = FN_TEST_CON;
                end
              end
            end
            default: begin
              rx_phase_next = (rx_byte == START_BYTE) ? PH_LEN : PH_START;
            end
          endcase
        end
        KIND_CONN: begin
          session_started_next = 1'b0;
          send_sequence_next = '0;
          receive_sequence_next = '0;
          rx_phase_next = PH_START;
          body_count_next = '0;
        end
        KIND_POINT: begin
          point_bit_next = point_value;
          if (session_started) begin
            job.valid = 1'b1;
            job.first = FR_POINT3;
            send_sequence_next = send_sequence + 15'd1;
          end
        end
        default: begin
          job.valid = 1'b0;
        end
      endcase
    end
    job.rsn = receive_sequence_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase <= PH_START;
      frame_length <= '0;
      body_count <= '0;
      session_started <= 1'b0;
      send_sequence <= '0;
      receive_sequence <= '0;
      point_bit <= 1'b0;
    end else begin
      rx_phase <= rx_phase_next;
      frame_length <= frame_length_next;
      body_count <= body_count_next;
      session_started <= session_started_next;
      send_sequence <= send_sequence_next;
      receive_sequence <= receive_sequence_next;
      point_bit <= point_bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_BYTE && rx_phase == PH_BODY &&
        body_count < 8'(STORE_BYTES)) begin
      body_store[body_count[3:0]] <= rx_byte;
    end
  end

endmodule

// ===== design/tcas_tx.sv =====
// transmit frame builder and four-byte word sequencer with output register
module tcas_tx (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tcas_pkg::job_t    job,
  input  tcas_pkg::cfg_t    cfg,
  input  logic              point_bit,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [39:0]       m_tdata,
  output logic              m_tlast,
  output logic              free
);
  import tcas_pkg::*;

  logic        active;
  frame_kind_t fr;
  logic [2:0]  word;
  logic [1:0]  iidx;
  logic        gi;
  logic [7:0]  ufn;
  logic [14:0] ssn_base;
  logic [14:0] rsn;
  logic [79:0] asdu;

  logic [7:0]  fb [20];
  logic [7:0]  wb [4];
  logic [4:0]  flen;
  logic [2:0]  last_word_idx;
  logic [4:0]  rem;
  logic [2:0]  cnt;
  logic        last_word;
  logic        has_next;
  frame_kind_t fr_next;
  logic        final_word;
  logic        load;
  logic [14:0] ssn_f;

  always_comb begin
    for (int i = 0; i < 20; i++) begin
      fb[i] = '0;
    end
    ssn_f = ssn_base + 15'(iidx);
    fb[0] = START_BYTE;
    fb[2] = {ssn_f[6:0], 1'b0};
    fb[3] = ssn_f[14:7];
    fb[4] = {rsn[6:0], 1'b0};
    fb[5] = rsn[14:7];
    fb[7] = 8'h01;
    fb[10] = cfg.common_address[7:0];
    fb[11] = cfg.common_address[15:8];
    flen = 5'd16;
    last_word_idx = 3'd3;
    case (fr)
      FR_U: begin
        fb[2] = ufn;
        fb[3] = '0;
        fb[4] = '0;
        fb[5] = '0;
        fb[7] = '0;
        fb[10] = '0;
        fb[11] = '0;
        flen = 5'd6;
        last_word_idx = 3'd1;
      end
      FR_ECHO7, FR_ECHO10: begin
        for (int k = 0; k < 10; k++) begin
          fb[6+k] = asdu[8*k +: 8];
        end
        fb[8] = (fr == FR_ECHO7) ? COT_ACTCON : COT_ACTTERM;
      end
      FR_VOLT: begin
        fb[6] = TYPE_FLOAT;
        fb[8] = COT_INROGEN;
        fb[12] = cfg.voltage_ioa[7:0];
        fb[13] = cfg.voltage_ioa[15:8];
        fb[14] = cfg.voltage_ioa[23:16];
        fb[15] = cfg.voltage_word[7:0];
        fb[16] = cfg.voltage_word[15:8];
        fb[17] = cfg.voltage_word[23:16];
        fb[18] = cfg.voltage_word[31:24];
        flen = 5'd20;
        last_word_idx = 3'd4;
      end
      default: begin
        fb[6] = TYPE_SP;
        fb[8] = (fr == FR_POINT3) ? COT_SPONT : COT_INROGEN;
        fb[12] = cfg.point_ioa[7:0];
        fb[13] = cfg.point_ioa[15:8];
        fb[14] = cfg.point_ioa[23:16];
        fb[15] = {7'd0, point_bit};
      end
    endcase
    fb[1] = {3'd0, flen - 5'd2};
    for (int k = 0; k < 4; k++) begin
      wb[k] = fb[5'({word, 2'b00}) + 5'(k)];
    end
    rem = flen - 5'({word, 2'b00});
    cnt = (rem >= 5'd4) ? 3'd4 : rem[2:0];
    last_word = (word == last_word_idx);
  end

  always_comb begin
    has_next = 1'b0;
    fr_next = FR_ECHO10;
    case (fr)
      FR_ECHO7: begin
        has_next = gi;
        fr_next = FR_POINT20;
      end
      FR_POINT20: begin
        has_next = 1'b1;
        fr_next = cfg.voltage_en ? FR_VOLT : FR_ECHO10;
      end
      FR_VOLT: begin
        has_next = 1'b1;
      end
      default: begin
        has_next = 1'b0;
      end
    endcase
    final_word = last_word && !has_next;
    load = active && (!m_tvalid || m_tready);
    free = !active || (load && final_word);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (start) begin
        active <= 1'b1;
      end else if (load && final_word) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {3'd0, point_bit, last_word, cnt, wb[3], wb[2], wb[1], wb[0]};
      m_tlast <= final_word;
      if (last_word) begin
        fr <= fr_next;
        word <= '0;
        iidx <= iidx + 2'd1;
      end else begin
        word <= word + 3'd1;
      end
    end
    if (start) begin
      fr <= job.first;
      word <= '0;
      iidx <= '0;
      gi <= job.gi;
      ufn <= job.ufn;
      ssn_base <= job.ssn;
      rsn <= job.rsn;
      asdu <= job.asdu;
    end
  end

endmodule

// ===== design/telecontrol_apdu_slave_engine.sv =====
// top level of the telecontrol apdu slave engine
// an accepted item's job is registered into the transmit sequencer, each result
// word into the output register; throughput: one item per cycle when it causes
// no result, otherwise one result word per cycle unless m_tready is low; a new
// item is taken with the final word of the last; reset: synchronous, clears
// session, sequence numbers, deframer, point and loads the register reset values
module telecontrol_apdu_slave_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_byte, point_value
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // tx_bytes, byte_count, frame_end, point_state
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tcas_pkg::*;

  cfg_t cfg;
  job_t job;
  logic point_bit;
  logic accept;
  logic free;

  assign cfg_ready = 1'b1;
  assign s_tready = free;
  assign accept = s_tvalid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.common_address <= 16'd1;
      cfg.control_ioa <= 24'd1;
      cfg.point_ioa <= 24'd2;
      cfg.voltage_ioa <= 24'd3;
      cfg.voltage_en <= 1'b0;
      cfg.voltage_word <= 32'h435C0000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COMMON_ADDR:  cfg.common_address <= cfg_data[15:0];
        REG_CONTROL_IOA:  cfg.control_ioa <= cfg_data[23:0];
        REG_POINT_IOA:    cfg.point_ioa <= cfg_data[23:0];
        REG_VOLTAGE_IOA:  cfg.voltage_ioa <= cfg_data[23:0];
        REG_VOLTAGE_EN:   cfg.voltage_en <= cfg_data[0];
        REG_VOLTAGE_WORD: cfg.voltage_word <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tcas_rx u_rx (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (s_tuser),
    .rx_byte     (s_tdata[7:0]),
    .point_value (s_tdata[8]),
    .cfg         (cfg),
    .job         (job),
    .point_bit   (point_bit)
  );

  tcas_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && job.valid),
    .job       (job),
    .cfg       (cfg),
    .point_bit (point_bit),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .free      (free)
  );

endmodule

// ===== design/tcas_checker.sv =====
// port checker for the telecontrol apdu slave engine and its bind
`include "telecontrol_apdu_slave_engine_defines.svh"

module tcas_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  `TCAS_ASSERT_SAME(a_count_range, m_tvalid, m_tdata[34:32] != 3'd0 && m_tdata[34:32] <= 3'd4)
  `TCAS_ASSERT_SAME(a_last_ends_frame, m_tvalid && m_tlast, m_tdata[35])
  `TCAS_ASSERT_SAME(a_short_ends_frame, m_tvalid && m_tdata[34:32] != 3'd4, m_tdata[35])
  `TCAS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

endmodule

bind telecontrol_apdu_slave_engine tcas_checker u_tcas_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
